// ===== rtl/vsc_pkg.sv =====
package vsc_pkg;

    localparam int unsigned TimeW = 16;
    localparam int unsigned GenW  = 32;

    typedef enum logic [2:0] {
        CMD_BEGIN    = 3'd0,
        CMD_RELEASED = 3'd1,
        CMD_SPEECH   = 3'd2,
        CMD_FINISH   = 3'd3,
        CMD_CANCEL   = 3'd4,
        CMD_ALARM    = 3'd5,
        CMD_RESULT   = 3'd6,
        CMD_TICK     = 3'd7
    } t_cmd_e;

    typedef enum logic [3:0] {
        PH_READY          = 4'd0,
        PH_WAIT           = 4'd1,
        PH_LISTEN         = 4'd2,
        PH_RECOG          = 4'd3,
        PH_DONE           = 4'd4,
        PH_NOVOICE        = 4'd5,
        PH_NOT_UNDERSTOOD = 4'd6,
        PH_TARGET_MISSING = 4'd7,
        PH_ENGINE_MISSING = 4'd8,
        PH_CANCELLED      = 4'd9,
        PH_FAILED         = 4'd10
    } t_phase_e;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_START    = 3'd1,
        ACT_FINISH   = 3'd2,
        ACT_CANCEL   = 3'd3,
        ACT_COMPLETE = 3'd4,
        ACT_READY    = 3'd5
    } t_action_e;

    typedef enum logic [2:0] {
        RC_MATCHED        = 3'd0,
        RC_NO_VOICE       = 3'd1,
        RC_NOT_UNDERSTOOD = 3'd2,
        RC_TARGET_MISSING = 3'd3,
        RC_ENGINE_MISSING = 3'd4,
        RC_ERROR          = 3'd5
    } t_rcode_e;

    typedef enum logic [1:0] {
        REG_RELEASE_TIMEOUT   = 2'd0,
        REG_LISTEN_TIMEOUT    = 2'd1,
        REG_RECOGNIZE_TIMEOUT = 2'd2,
        REG_FEEDBACK_HOLD     = 2'd3
    } t_reg_e;

    localparam logic [TimeW-1:0] RstReleaseTimeout   = 16'd10000;
    localparam logic [TimeW-1:0] RstListenTimeout    = 16'd8000;
    localparam logic [TimeW-1:0] RstRecognizeTimeout = 16'd10000;
    localparam logic [TimeW-1:0] RstFeedbackHold     = 16'd1500;

    typedef struct packed {
        logic [TimeW-1:0] release_timeout;
        logic [TimeW-1:0] listen_timeout;
        logic [TimeW-1:0] recognize_timeout;
        logic [TimeW-1:0] feedback_hold;
    } t_cfg;

    typedef struct packed {
        t_phase_e         phase;
        logic [GenW-1:0]  generation;
        logic [TimeW-1:0] elapsed;
        logic             speech_seen;
    } t_state;

    typedef struct packed {
        logic [2:0]      command;
        logic            engine_ready;
        logic [GenW-1:0] result_generation;
        logic [2:0]      result_code;
        logic [TimeW-1:0] tick_ms;
    } t_item;

    typedef struct packed {
        t_action_e       action;
        logic            accepted;
        t_phase_e        phase_now;
        logic [GenW-1:0] generation_now;
        logic            is_active;
        logic            is_processing;
    } t_result;

endpackage

// ===== rtl/vsc_in_if.sv =====
interface vsc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic        engine_ready;
    logic [31:0] result_generation;
    logic [2:0]  result_code;
    logic [15:0] tick_ms;

    modport source (
        output valid, command, engine_ready, result_generation, result_code, tick_ms,
        input  ready
    );
    modport sink (
        input  valid, command, engine_ready, result_generation, result_code, tick_ms,
        output ready
    );
endinterface

// ===== rtl/vsc_out_if.sv =====
interface vsc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic        accepted;
    logic [3:0]  phase_now;
    logic [31:0] generation_now;
    logic        is_active;
    logic        is_processing;

    modport source (
        output valid, action, accepted, phase_now, generation_now, is_active, is_processing,
        input  ready
    );
    modport sink (
        input  valid, action, accepted, phase_now, generation_now, is_active, is_processing,
        output ready
    );
endinterface

// ===== rtl/voice_session_controller.sv =====
// Channel    Direction  Beat contents
// i_cmd      in         command, engine_ready, result_generation, result_code, tick_ms
// o_res      out        action, accepted, phase_now, generation_now, is_active, is_processing
// i_cfg_*    in         register index and 16-bit value, written when i_cfg_we is high
//
// Each beat is registered on input; its result and the new session state then load together.
// One beat is taken every cycle while the output is not stalled.
// Reset is synchronous and returns the timeouts to their defaults and the session to ready.
// A stalled output holds its beat while one further command waits in the input register.
module voice_session_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vsc_in_if.sink      i_cmd,
    vsc_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import vsc_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    advance;
    logic    in_take;

    assign advance = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign in_take = i_cmd.valid && i_cmd.ready;

    vsc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    vsc_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.command <= i_cmd.command;
            r_item.engine_ready <= i_cmd.engine_ready;
            r_item.result_generation <= i_cmd.result_generation;
            r_item.result_code <= i_cmd.result_code;
            r_item.tick_ms <= i_cmd.tick_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= PH_READY;
            r_state.generation <= '0;
            r_state.elapsed <= '0;
            r_state.speech_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.action = r_res.action;
    assign o_res.accepted = r_res.accepted;
    assign o_res.phase_now = r_res.phase_now;
    assign o_res.generation_now = r_res.generation_now;
    assign o_res.is_active = r_res.is_active;
    assign o_res.is_processing = r_res.is_processing;

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("session state changed without a command");

    a_start_listens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.action == ACT_START |-> o_res.phase_now == PH_LISTEN)
        else $error("start listening reported outside the listening phase");

    a_begin_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && t_cmd_e'(r_item.command) == CMD_BEGIN && n_res.accepted
        |=> r_state.generation != '0)
        else $error("accepted begin left generation at zero");

    a_result_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid && r_res.phase_now == r_state.phase &&
                    r_res.generation_now == r_state.generation)
        else $error("result beat disagrees with session state");

endmodule

// ===== rtl/vsc_cfg_regs.sv =====
module vsc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    output vsc_pkg::t_cfg o_cfg
);
    import vsc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_e'(i_cfg_idx))
                REG_RELEASE_TIMEOUT:   n_cfg.release_timeout   = i_cfg_data;
                REG_LISTEN_TIMEOUT:    n_cfg.listen_timeout    = i_cfg_data;
                REG_RECOGNIZE_TIMEOUT: n_cfg.recognize_timeout = i_cfg_data;
                REG_FEEDBACK_HOLD:     n_cfg.feedback_hold     = i_cfg_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_timeout   <= RstReleaseTimeout;
            r_cfg.listen_timeout    <= RstListenTimeout;
            r_cfg.recognize_timeout <= RstRecognizeTimeout;
            r_cfg.feedback_hold     <= RstFeedbackHold;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/vsc_step.sv =====
module vsc_step (
    input  vsc_pkg::t_state  i_state,
    input  vsc_pkg::t_cfg    i_cfg,
    input  vsc_pkg::t_item   i_item,
    output vsc_pkg::t_state  o_state,
    output vsc_pkg::t_result o_result
);
    import vsc_pkg::*;

    t_state          nxt;
    t_action_e       act;
    logic            acc;
    logic [GenW-1:0] gen_inc;
    logic [TimeW:0]  sum;
    logic [TimeW-1:0] elapsed_sat;
    t_phase_e        listen_end_phase;
    t_action_e       listen_end_act;
    t_phase_e        result_phase;
    logic            code_ok;
    logic            busy;

    assign gen_inc = (i_state.generation == '1) ? GenW'(1) : i_state.generation + GenW'(1);
    assign sum = {1'b0, i_state.elapsed} + {1'b0, i_item.tick_ms};
    assign elapsed_sat = sum[TimeW] ? '1 : sum[TimeW-1:0];
    assign listen_end_phase = i_state.speech_seen ? PH_RECOG : PH_NOVOICE;
    assign listen_end_act = i_state.speech_seen ? ACT_FINISH : ACT_CANCEL;
    assign busy = (i_state.phase inside {PH_WAIT, PH_LISTEN, PH_RECOG});

    always_comb begin
        code_ok = 1'b1;
        case (t_rcode_e'(i_item.result_code))
            RC_MATCHED:        result_phase = PH_DONE;
            RC_NO_VOICE:       result_phase = PH_NOVOICE;
            RC_NOT_UNDERSTOOD: result_phase = PH_NOT_UNDERSTOOD;
            RC_TARGET_MISSING: result_phase = PH_TARGET_MISSING;
            RC_ENGINE_MISSING: result_phase = PH_ENGINE_MISSING;
            RC_ERROR:          result_phase = PH_FAILED;
            default: begin
                result_phase = PH_READY;
                code_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        nxt = i_state;
        act = ACT_NONE;
        acc = 1'b0;
        case (t_cmd_e'(i_item.command))
            CMD_BEGIN: begin
                if (i_state.phase == PH_READY) begin
                    nxt.generation = gen_inc;
                    nxt.speech_seen = 1'b0;
                    nxt.phase = i_item.engine_ready ? PH_WAIT : PH_ENGINE_MISSING;
                    nxt.elapsed = '0;
                    acc = 1'b1;
                end
            end
            CMD_RELEASED: begin
                if (i_state.phase == PH_WAIT) begin
                    nxt.phase = PH_LISTEN;
                    nxt.elapsed = '0;
                    act = ACT_START;
                end
            end
            CMD_SPEECH: begin
                if (i_state.phase == PH_LISTEN) begin
                    nxt.speech_seen = 1'b1;
                end
            end
            CMD_FINISH: begin
                if (i_state.phase == PH_LISTEN) begin
                    nxt.phase = listen_end_phase;
                    nxt.elapsed = '0;
                    act = listen_end_act;
                end
            end
            CMD_CANCEL: begin
                if (busy) begin
                    nxt.generation = gen_inc;
                    nxt.speech_seen = 1'b0;
                    nxt.phase = PH_CANCELLED;
                    nxt.elapsed = '0;
                    act = ACT_CANCEL;
                end
            end
            CMD_ALARM: begin
                if (i_state.phase != PH_READY) begin
                    nxt.generation = gen_inc;
                    nxt.speech_seen = 1'b0;
                    nxt.phase = PH_READY;
                    nxt.elapsed = '0;
                    act = ACT_CANCEL;
                end
            end
            CMD_RESULT: begin
                if (i_state.phase == PH_RECOG && i_item.result_generation != '0 &&
                    i_item.result_generation == i_state.generation && code_ok) begin
                    nxt.phase = result_phase;
                    nxt.elapsed = '0;
                    nxt.speech_seen = 1'b0;
                    acc = 1'b1;
                end
            end
            default: begin
                if (i_state.phase != PH_READY) begin
                    nxt.elapsed = elapsed_sat;
                    case (i_state.phase)
                        PH_WAIT: begin
                            if (elapsed_sat >= i_cfg.release_timeout) begin
                                nxt.generation = gen_inc;
                                nxt.speech_seen = 1'b0;
                                nxt.phase = PH_CANCELLED;
                                nxt.elapsed = '0;
                                act = ACT_CANCEL;
                            end
                        end
                        PH_LISTEN: begin
                            if (elapsed_sat >= i_cfg.listen_timeout) begin
                                nxt.phase = listen_end_phase;
                                nxt.elapsed = '0;
                                act = listen_end_act;
                            end
                        end
                        PH_RECOG: begin
                            if (elapsed_sat >= i_cfg.recognize_timeout) begin
                                nxt.generation = gen_inc;
                                nxt.speech_seen = 1'b0;
                                nxt.phase = PH_FAILED;
                                nxt.elapsed = '0;
                                act = ACT_CANCEL;
                            end
                        end
                        default: begin
                            if (elapsed_sat >= i_cfg.feedback_hold) begin
                                act = (i_state.phase == PH_DONE) ? ACT_COMPLETE : ACT_READY;
                                nxt.speech_seen = 1'b0;
                                nxt.phase = PH_READY;
                                nxt.elapsed = '0;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    assign o_state = nxt;
    assign o_result.action = act;
    assign o_result.accepted = acc;
    assign o_result.phase_now = nxt.phase;
    assign o_result.generation_now = nxt.generation;
    assign o_result.is_active = (nxt.phase != PH_READY);
    assign o_result.is_processing = (nxt.phase inside {PH_WAIT, PH_LISTEN, PH_RECOG});

endmodule
